@@ hdl/sum_pkg.sv @@
// Shared constants, types and opcode codes for the segmented universal machine core.
package sum_pkg;
	localparam int NUM_SEGMENTS = 64;
	localparam int SEGMENT_WORDS = 1024;
	localparam int SEG_W = $clog2(NUM_SEGMENTS);
	localparam int OFF_W = $clog2(SEGMENT_WORDS);
	localparam int LEN_W = OFF_W + 1;
	localparam int CNT_W = SEG_W + 1;
	localparam int ADDR_W = SEG_W + OFF_W;
	localparam int OP_SHIFT = 28;
	localparam int LV_REG_SHIFT = 25;
	localparam int WORD_BYTE_TOP = 24;
	localparam logic [31:0] OUT_LIMIT = 32'd256;

	localparam logic [3:0] OP_CMOV = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_STORE = 4'd2;
	localparam logic [3:0] OP_ADD = 4'd3;
	localparam logic [3:0] OP_MUL = 4'd4;
	localparam logic [3:0] OP_DIV = 4'd5;
	localparam logic [3:0] OP_NAND = 4'd6;
	localparam logic [3:0] OP_HALT = 4'd7;
	localparam logic [3:0] OP_MAP = 4'd8;
	localparam logic [3:0] OP_UNMAP = 4'd9;
	localparam logic [3:0] OP_OUT = 4'd10;
	localparam logic [3:0] OP_IN = 4'd11;
	localparam logic [3:0] OP_LDPRG = 4'd12;
	localparam logic [3:0] OP_LDVAL = 4'd13;

	localparam logic [2:0] F_NONE = 3'd0;
	localparam logic [2:0] F_DIV = 3'd1;
	localparam logic [2:0] F_SEG = 3'd2;
	localparam logic [2:0] F_MAP = 3'd3;
	localparam logic [2:0] F_OUT = 3'd4;
	localparam logic [2:0] F_UNMAP = 3'd5;
	localparam logic [2:0] F_PC = 3'd6;
	localparam logic [2:0] F_OP = 3'd7;

	typedef struct packed {
		logic        opcode;
		logic [31:0] load_word;
		logic [7:0]  in_char;
		logic        in_eof;
	} req_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_char;
		logic       in_consumed;
		logic       halted;
		logic       fault;
		logic [2:0] fault_code;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // latch the request
		logic append;    // write load word into segment 0
		logic fetch;     // read instruction at pc
		logic decode;    // latch instruction and operands
		logic exec;      // perform the execute-state part of the instruction
		logic mem_rd;    // issue segment load read
		logic mem_wb;    // write back segment load data
		logic div_start;
		logic div_wb;
		logic map_step;  // zero one word of the new segment
		logic map_done;
		logic cp_rd;     // read a source word of load program
		logic cp_wr;     // write the copied word
		logic cp_done;
		logic mul_wb;
		logic respond;
	} cmd_t;

	typedef struct packed {
		logic       is_run;
		logic       stopped;
		logic       pc_ok;
		logic [3:0] op;
		logic [2:0] fault;   // fault detected by decode checks, F_NONE if none
		logic       div_busy;
		logic       sweep_last;
		logic       cp_skip;
	} sts_t;
endpackage

@@ hdl/sum_if.sv @@
// Valid/ready channel interface carrying one request or result.
interface sum_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hdl/segmented_universal_machine_core.sv @@
// Top level of the segmented universal machine core.
// Each request either appends a program word to segment 0 or runs one instruction and
// yields one result. Run requests pass through the single-port fetch, decode and execute
// sequence of the controller. Multiply adds a writeback state, a segment load a read and
// a writeback state, divide waits for the divider (one quotient bit per cycle), map zeroes
// the new segment one word a cycle, and a load program from a nonzero segment copies it
// into segment 0 word by word.
module segmented_universal_machine_core (
	input logic clk,
	input logic arst_n,
	sum_if.sink   req,
	sum_if.source rsp
);
	sum_pkg::cmd_t cmd;
	sum_pkg::sts_t sts;

	sum_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts(sts), .cmd(cmd)
	);

	sum_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .req(req.data), .cmd(cmd), .sts(sts), .rsp(rsp.data)
	);
endmodule

@@ hdl/sum_div.sv @@
// Radix-2 restoring divider for 32-bit unsigned operands, one quotient bit per cycle.
module sum_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [31:0] rem_q, quo_q, dsr_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dsr_q};
	assign busy = (cnt_q != 6'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 32'd0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule

@@ hdl/sum_datapath.sv @@
// Datapath: registers, segment memory, segment tables, divider and result formation.
module sum_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  sum_pkg::req_t  req,
	input  sum_pkg::cmd_t  cmd,
	output sum_pkg::sts_t  sts,
	output sum_pkg::rsp_t  rsp
);
	localparam int SW = sum_pkg::SEG_W;
	localparam int OW = sum_pkg::OFF_W;
	localparam int LW = sum_pkg::LEN_W;
	localparam int CW = sum_pkg::CNT_W;
	localparam int AW = sum_pkg::ADDR_W;
	localparam int NS = sum_pkg::NUM_SEGMENTS;
	localparam int SWD = sum_pkg::SEGMENT_WORDS;

	sum_pkg::req_t req_q;
	logic [31:0] regs_q [8];
	logic [LW-1:0] pc_q;
	logic [31:0] mem [NS*SWD];
	logic [31:0] rdata_q;
	logic [LW-1:0] len_q [NS];
	logic [LW-1:0] len0_q;
	logic [LW-1:0] lenrd_q;
	logic lenz_q;
	logic [NS-1:0] mapped_q;
	logic [SW-1:0] fstack [NS];
	logic [SW-1:0] ftop_q;
	logic [CW-1:0] fcnt_q;
	logic [CW-1:0] fresh_q;
	logic stopped_q;
	logic [2:0] fault_q;
	logic outv_q, inc_q;
	logic [7:0] outc_q;

	logic [31:0] ins_q, ra_q, rb_q, rc_q;
	logic [63:0] prod_q;
	logic [SW-1:0] seg_q;
	logic [OW:0] sweep_q;

	logic [3:0] op;
	logic [2:0] ia, ib, ic, il;
	logic [31:0] div_q;
	logic div_busy;

	assign op = ins_q[31:sum_pkg::OP_SHIFT];
	assign ia = ins_q[8:6];
	assign ib = ins_q[5:3];
	assign ic = ins_q[2:0];
	assign il = ins_q[sum_pkg::LV_REG_SHIFT+2:sum_pkg::LV_REG_SHIFT];

	sum_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(rb_q), .divisor(rc_q), .busy(div_busy), .quotient(div_q)
	);

	function automatic logic seg_ok(input logic [31:0] s, input logic [NS-1:0] m);
		seg_ok = (s < 32'(NS)) && m[s[SW-1:0]];
	endfunction

	logic a_seg_ok, b_seg_ok, c_seg_ok;
	logic [LW-1:0] len_x;
	logic [31:0] lseg;
	assign a_seg_ok = seg_ok(ra_q, mapped_q);
	assign b_seg_ok = seg_ok(rb_q, mapped_q);
	assign c_seg_ok = seg_ok(rc_q, mapped_q);

	// The segment whose length an instruction needs is looked up while it is decoded.
	assign lseg = (rdata_q[31:sum_pkg::OP_SHIFT] == sum_pkg::OP_STORE) ?
		regs_q[rdata_q[8:6]] : regs_q[rdata_q[5:3]];
	assign len_x = lenz_q ? len0_q : lenrd_q;

	// Map id selection.
	logic use_free, use_fresh;
	logic [SW-1:0] new_id;
	assign use_free = (fcnt_q != '0);
	assign use_fresh = !use_free && (fresh_q < CW'(NS));
	assign new_id = use_free ? ftop_q : fresh_q[SW-1:0];

	// Length of segment 0 that load program will produce.
	logic [LW-1:0] len0_new;
	assign len0_new = (rb_q == 32'd0) ? len0_q : len_x;

	always_comb begin
		sts.fault = sum_pkg::F_NONE;
		unique case (op)
			sum_pkg::OP_LOAD:
				if (!b_seg_ok || rc_q >= 32'(len_x)) sts.fault = sum_pkg::F_SEG;
			sum_pkg::OP_STORE:
				if (!a_seg_ok || rb_q >= 32'(len_x)) sts.fault = sum_pkg::F_SEG;
			sum_pkg::OP_DIV:
				if (rc_q == 32'd0) sts.fault = sum_pkg::F_DIV;
			sum_pkg::OP_MAP:
				if (rc_q > 32'(SWD) || (!use_free && !use_fresh)) sts.fault = sum_pkg::F_MAP;
			sum_pkg::OP_UNMAP:
				if (rc_q == 32'd0 || !c_seg_ok || fcnt_q >= CW'(NS))
					sts.fault = sum_pkg::F_UNMAP;
			sum_pkg::OP_OUT:
				if (rc_q >= sum_pkg::OUT_LIMIT) sts.fault = sum_pkg::F_OUT;
			sum_pkg::OP_LDPRG:
				if (rb_q != 32'd0 && !b_seg_ok) sts.fault = sum_pkg::F_SEG;
				else if (rc_q >= 32'(len0_new)) sts.fault = sum_pkg::F_PC;
			4'd14, 4'd15: sts.fault = sum_pkg::F_OP;
			default: sts.fault = sum_pkg::F_NONE;
		endcase
	end

	assign sts.is_run = req_q.opcode;
	assign sts.stopped = stopped_q;
	assign sts.pc_ok = (pc_q < len0_q);
	assign sts.op = op;
	assign sts.div_busy = div_busy;
	assign sts.sweep_last = (sweep_q == (OW+1)'(SWD - 1)) || (sweep_q == (OW+1)'(SWD));
	assign sts.cp_skip = (rb_q == 32'd0);

	// Memory address and write data.
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata;
	logic we, re;
	always_comb begin
		we = 1'b0; re = 1'b0;
		waddr = '0; raddr = '0; wdata = '0;
		if (cmd.append) begin
			we = (len0_q < LW'(SWD));
			waddr = {SW'(0), len0_q[OW-1:0]};
			wdata = req_q.load_word;
		end else if (cmd.exec && op == sum_pkg::OP_STORE) begin
			we = 1'b1;
			waddr = {ra_q[SW-1:0], rb_q[OW-1:0]};
			wdata = rc_q;
		end else if (cmd.map_step) begin
			we = 1'b1;
			waddr = {seg_q, sweep_q[OW-1:0]};
		end else if (cmd.cp_wr) begin
			we = 1'b1;
			waddr = {SW'(0), sweep_q[OW-1:0]};
			wdata = rdata_q;
		end
		if (cmd.fetch) begin
			re = 1'b1;
			raddr = {SW'(0), pc_q[OW-1:0]};
		end else if (cmd.mem_rd) begin
			re = 1'b1;
			raddr = {rb_q[SW-1:0], rc_q[OW-1:0]};
		end else if (cmd.cp_rd) begin
			re = 1'b1;
			raddr = {seg_q, sweep_q[OW-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= req;
		if (cmd.decode) begin
			ins_q <= rdata_q;
			ra_q <= regs_q[rdata_q[8:6]];
			rb_q <= regs_q[rdata_q[5:3]];
			rc_q <= regs_q[rdata_q[2:0]];
		end
		if (cmd.exec) prod_q <= rb_q * rc_q;
		if (cmd.exec) seg_q <= (op == sum_pkg::OP_MAP) ? new_id : rb_q[SW-1:0];
		if (cmd.exec) sweep_q <= '0;
		else if (cmd.map_step || cmd.cp_wr) sweep_q <= sweep_q + 1'b1;
	end

	// Segment lengths other than segment 0; only mapped entries are ever consulted.
	always_ff @(posedge clk) begin
		if (cmd.exec && op == sum_pkg::OP_MAP && sts.fault == sum_pkg::F_NONE)
			len_q[new_id] <= LW'(rc_q);
		if (cmd.decode) begin
			lenrd_q <= len_q[lseg[SW-1:0]];
			lenz_q <= (lseg[SW-1:0] == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && op == sum_pkg::OP_UNMAP && sts.fault == sum_pkg::F_NONE)
			fstack[fcnt_q[SW-1:0]] <= rc_q[SW-1:0];
		ftop_q <= fstack[fcnt_q[SW-1:0] - SW'(1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) regs_q[i] <= 32'd0;
			pc_q <= '0;
			len0_q <= '0;
			mapped_q <= NS'(1);
			fcnt_q <= '0;
			fresh_q <= CW'(1);
			stopped_q <= 1'b0;
			fault_q <= sum_pkg::F_NONE;
			outv_q <= 1'b0;
			outc_q <= 8'd0;
			inc_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				outv_q <= 1'b0;
				outc_q <= 8'd0;
				inc_q <= 1'b0;
			end
			if (cmd.append && len0_q < LW'(SWD)) len0_q <= len0_q + 1'b1;
			if (cmd.fetch && !sts.pc_ok) begin
				stopped_q <= 1'b1;
				fault_q <= sum_pkg::F_PC;
			end
			if (cmd.fetch && sts.pc_ok) pc_q <= pc_q + 1'b1;
			if (cmd.exec) begin
				if (sts.fault != sum_pkg::F_NONE) begin
					stopped_q <= 1'b1;
					fault_q <= sts.fault;
				end else begin
					case (op)
						sum_pkg::OP_CMOV: if (rc_q != 32'd0) regs_q[ia] <= rb_q;
						sum_pkg::OP_ADD: regs_q[ia] <= rb_q + rc_q;
						sum_pkg::OP_NAND: regs_q[ia] <= ~(rb_q & rc_q);
						sum_pkg::OP_HALT: stopped_q <= 1'b1;
						sum_pkg::OP_MAP: begin
							if (use_free) fcnt_q <= fcnt_q - 1'b1;
							else fresh_q <= fresh_q + 1'b1;
							mapped_q[new_id] <= 1'b1;
							regs_q[ib] <= 32'(new_id);
						end
						sum_pkg::OP_UNMAP: begin
							mapped_q[rc_q[SW-1:0]] <= 1'b0;
							fcnt_q <= fcnt_q + 1'b1;
						end
						sum_pkg::OP_OUT: begin
							outv_q <= 1'b1;
							outc_q <= rc_q[7:0];
						end
						sum_pkg::OP_IN: begin
							regs_q[ic] <= req_q.in_eof ? 32'hFFFF_FFFF : {24'd0, req_q.in_char};
							inc_q <= 1'b1;
						end
						sum_pkg::OP_LDPRG: begin
							pc_q <= rc_q[LW-1:0];
							if (rb_q != 32'd0) len0_q <= len_x;
						end
						sum_pkg::OP_LDVAL:
							regs_q[il] <= {7'd0, ins_q[sum_pkg::WORD_BYTE_TOP:0]};
						default: ;
					endcase
				end
			end
			if (cmd.mem_wb) regs_q[ia] <= rdata_q;
			if (cmd.mul_wb) regs_q[ia] <= prod_q[31:0];
			if (cmd.div_wb) regs_q[ia] <= div_q;
		end
	end

	assign rsp.out_valid = outv_q;
	assign rsp.out_char = outc_q;
	assign rsp.in_consumed = inc_q;
	assign rsp.halted = stopped_q;
	assign rsp.fault = (fault_q != sum_pkg::F_NONE);
	assign rsp.fault_code = fault_q;

	logic unused;
	assign unused = cmd.map_done ^ cmd.cp_done ^ cmd.respond ^ (^prod_q[63:32]);

	property p_fault_stops;
		@(posedge clk) disable iff (!arst_n) (fault_q != sum_pkg::F_NONE) |-> stopped_q;
	endproperty
	a_fault_stops: assert property (p_fault_stops) else $error("fault without stop");

	property p_fault_sticky;
		@(posedge clk) disable iff (!arst_n) stopped_q |=> stopped_q;
	endproperty
	a_fault_sticky: assert property (p_fault_sticky) else $error("stop cleared");

	property p_seg0_mapped;
		@(posedge clk) disable iff (!arst_n) mapped_q[0];
	endproperty
	a_seg0_mapped: assert property (p_seg0_mapped) else $error("segment 0 unmapped");
endmodule

@@ hdl/sum_ctrl.sv @@
// Controller state machine sequencing fetch, execute, sweeps and the response.
module sum_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  sum_pkg::sts_t sts,
	output sum_pkg::cmd_t cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_FETCH = 4'd2;
	localparam logic [3:0] S_DEC = 4'd3;
	localparam logic [3:0] S_EXEC = 4'd4;
	localparam logic [3:0] S_MEMRD = 4'd5;
	localparam logic [3:0] S_MEMWB = 4'd6;
	localparam logic [3:0] S_DIV = 4'd7;
	localparam logic [3:0] S_MUL = 4'd8;
	localparam logic [3:0] S_MAP = 4'd9;
	localparam logic [3:0] S_CPRD = 4'd10;
	localparam logic [3:0] S_CPWR = 4'd11;
	localparam logic [3:0] S_RESP = 4'd12;
	localparam logic [3:0] S_WAIT = 4'd13;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESP);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.capture = 1'b1;
				state_d = S_DISP;
			end
			S_DISP:
				if (!sts.is_run) begin
					cmd.append = 1'b1;
					state_d = S_RESP;
				end else if (sts.stopped) state_d = S_RESP;
				else state_d = S_FETCH;
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = sts.pc_ok ? S_DEC : S_RESP;
			end
			S_DEC: begin
				cmd.decode = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = S_RESP;
				if (sts.fault == sum_pkg::F_NONE) begin
					case (sts.op)
						sum_pkg::OP_LOAD: state_d = S_MEMRD;
						sum_pkg::OP_MUL: state_d = S_MUL;
						sum_pkg::OP_DIV: begin
							cmd.div_start = 1'b1;
							state_d = S_DIV;
						end
						sum_pkg::OP_MAP: state_d = S_MAP;
						sum_pkg::OP_LDPRG: state_d = sts.cp_skip ? S_RESP : S_CPRD;
						default: state_d = S_RESP;
					endcase
				end
			end
			S_MEMRD: begin
				cmd.mem_rd = 1'b1;
				state_d = S_MEMWB;
			end
			S_MEMWB: begin
				cmd.mem_wb = 1'b1;
				state_d = S_RESP;
			end
			S_MUL: begin
				cmd.mul_wb = 1'b1;
				state_d = S_RESP;
			end
			S_DIV: if (!sts.div_busy) begin
				cmd.div_wb = 1'b1;
				state_d = S_RESP;
			end
			S_MAP: begin
				cmd.map_step = 1'b1;
				if (sts.sweep_last) begin
					cmd.map_done = 1'b1;
					state_d = S_RESP;
				end
			end
			S_CPRD: begin
				cmd.cp_rd = 1'b1;
				state_d = S_CPWR;
			end
			S_CPWR: begin
				cmd.cp_wr = 1'b1;
				if (sts.sweep_last) begin
					cmd.cp_done = 1'b1;
					state_d = S_RESP;
				end else state_d = S_CPRD;
			end
			S_RESP: if (out_ready) begin
				cmd.respond = 1'b1;
				state_d = S_IDLE;
			end
			S_WAIT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	property p_one_request;
		@(posedge clk) disable iff (!arst_n) (in_valid && in_ready) |=> !in_ready;
	endproperty
	a_one_request: assert property (p_one_request) else $error("request overlap");

	property p_resp_excl;
		@(posedge clk) disable iff (!arst_n) !(out_valid && in_ready);
	endproperty
	a_resp_excl: assert property (p_resp_excl) else $error("ready while responding");

	property p_exec_after_dec;
		@(posedge clk) disable iff (!arst_n) cmd.exec |-> $past(cmd.decode);
	endproperty
	a_exec_after_dec: assert property (p_exec_after_dec) else $error("exec without decode");
endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the segmented universal machine core, with its own machine model.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 4_000_000;
	localparam int ITEMS = 2000;

	class um_shadow;
		logic [31:0] regs[8];
		bit [31:0] mem[sum_pkg::NUM_SEGMENTS * sum_pkg::SEGMENT_WORDS];
		int pc;
		int len[sum_pkg::NUM_SEGMENTS];
		bit mapped[sum_pkg::NUM_SEGMENTS];
		int fstack[sum_pkg::NUM_SEGMENTS];
		int fcount;
		int fresh;
		logic [2:0] lastf;
		bit stopped;
		sum_pkg::rsp_t due_results[$];
		int errors;
		int checked;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (len[i]) begin
				len[i] = 0;
				mapped[i] = 0;
			end
			mapped[0] = 1;
			pc = 0;
			fcount = 0;
			fresh = 1;
			lastf = sum_pkg::F_NONE;
			stopped = 0;
			errors = 0;
			checked = 0;
		endfunction

		function bit seg_ok(logic [31:0] s);
			return s < sum_pkg::NUM_SEGMENTS && mapped[s];
		endfunction

		function bit word_ok(logic [31:0] s, logic [31:0] o);
			return seg_ok(s) && o < len[s];
		endfunction

		function int at(logic [31:0] s, logic [31:0] o);
			return s * sum_pkg::SEGMENT_WORDS + o;
		endfunction

		function void halt_with(logic [2:0] f);
			stopped = 1;
			lastf = f;
		endfunction

		function bit would_stop(logic [31:0] w);
			logic [3:0] op;
			int a, b, c;
			op = w[31:28];
			a = w[8:6];
			b = w[5:3];
			c = w[2:0];
			case (op)
				sum_pkg::OP_LOAD: return !word_ok(regs[b], regs[c]);
				sum_pkg::OP_STORE: return !word_ok(regs[a], regs[b]);
				sum_pkg::OP_DIV: return regs[c] == 0;
				sum_pkg::OP_HALT, sum_pkg::OP_LDPRG: return 1;
				sum_pkg::OP_MAP: return regs[c] > sum_pkg::SEGMENT_WORDS ||
					(fcount == 0 && fresh >= sum_pkg::NUM_SEGMENTS);
				sum_pkg::OP_UNMAP: return regs[c] == 0 || !seg_ok(regs[c]);
				sum_pkg::OP_OUT: return regs[c] >= sum_pkg::OUT_LIMIT;
				default: return op > sum_pkg::OP_LDVAL;
			endcase
		endfunction

		function void execute(logic [31:0] w, sum_pkg::req_t q, inout sum_pkg::rsp_t e);
			logic [3:0] op;
			int a, b, c, id;
			logic [31:0] n;
			bit ok;
			op = w[31:28];
			a = w[8:6];
			b = w[5:3];
			c = w[2:0];
			case (op)
				sum_pkg::OP_CMOV: if (regs[c] != 0) regs[a] = regs[b];
				sum_pkg::OP_LOAD: begin
					if (!word_ok(regs[b], regs[c])) halt_with(sum_pkg::F_SEG);
					else regs[a] = mem[at(regs[b], regs[c])];
				end
				sum_pkg::OP_STORE: begin
					if (!word_ok(regs[a], regs[b])) halt_with(sum_pkg::F_SEG);
					else mem[at(regs[a], regs[b])] = regs[c];
				end
				sum_pkg::OP_ADD: regs[a] = regs[b] + regs[c];
				sum_pkg::OP_MUL: regs[a] = regs[b] * regs[c];
				sum_pkg::OP_DIV: begin
					if (regs[c] == 0) halt_with(sum_pkg::F_DIV);
					else regs[a] = regs[b] / regs[c];
				end
				sum_pkg::OP_NAND: regs[a] = ~(regs[b] & regs[c]);
				sum_pkg::OP_HALT: stopped = 1;
				sum_pkg::OP_MAP: begin
					n = regs[c];
					ok = 1;
					if (n > sum_pkg::SEGMENT_WORDS) ok = 0;
					else if (fcount > 0) begin
						id = fstack[fcount - 1];
						fcount--;
					end else if (fresh < sum_pkg::NUM_SEGMENTS) begin
						id = fresh;
						fresh++;
					end else ok = 0;
					if (!ok) halt_with(sum_pkg::F_MAP);
					else begin
						for (int k = 0; k < sum_pkg::SEGMENT_WORDS; k++) mem[at(id, k)] = '0;
						len[id] = n;
						mapped[id] = 1;
						regs[b] = id;
					end
				end
				sum_pkg::OP_UNMAP: begin
					if (regs[c] == 0 || !seg_ok(regs[c]) || fcount >= sum_pkg::NUM_SEGMENTS)
						halt_with(sum_pkg::F_UNMAP);
					else begin
						id = regs[c];
						mapped[id] = 0;
						len[id] = 0;
						fstack[fcount] = id;
						fcount++;
					end
				end
				sum_pkg::OP_OUT: begin
					if (regs[c] >= sum_pkg::OUT_LIMIT) halt_with(sum_pkg::F_OUT);
					else begin
						e.out_valid = 1;
						e.out_char = regs[c][7:0];
					end
				end
				sum_pkg::OP_IN: begin
					regs[c] = q.in_eof ? 32'hFFFF_FFFF : {24'b0, q.in_char};
					e.in_consumed = 1;
				end
				sum_pkg::OP_LDPRG: begin
					ok = 1;
					if (regs[b] != 0) begin
						if (!seg_ok(regs[b])) begin
							halt_with(sum_pkg::F_SEG);
							ok = 0;
						end else begin
							id = regs[b];
							for (int k = 0; k < sum_pkg::SEGMENT_WORDS; k++)
								mem[k] = mem[at(id, k)];
							len[0] = len[id];
						end
					end
					if (ok) begin
						if (regs[c] >= len[0]) halt_with(sum_pkg::F_PC);
						else pc = regs[c];
					end
				end
				sum_pkg::OP_LDVAL: regs[w[27:25]] = {7'b0, w[24:0]};
				default: halt_with(sum_pkg::F_OP);
			endcase
		endfunction

		function void note_request(sum_pkg::req_t q);
			sum_pkg::rsp_t e;
			logic [31:0] w;
			e = '0;
			if (!q.opcode) begin
				if (len[0] < sum_pkg::SEGMENT_WORDS) begin
					mem[len[0]] = q.load_word;
					len[0]++;
				end
			end else if (!stopped) begin
				if (pc >= len[0]) halt_with(sum_pkg::F_PC);
				else begin
					w = mem[pc];
					pc++;
					execute(w, q, e);
				end
			end
			e.halted = stopped;
			e.fault = lastf != sum_pkg::F_NONE;
			e.fault_code = lastf;
			due_results.push_back(e);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("tb: mismatch on %s at result %0d: got %0h, expected %0h",
				what, checked, got, want);
		endtask

		task check_result(sum_pkg::rsp_t g);
			sum_pkg::rsp_t e;
			checked++;
			if (due_results.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				e = due_results.pop_front();
				if (g.out_valid !== e.out_valid) report("out_valid", g.out_valid, e.out_valid);
				if (g.out_char !== e.out_char) report("out_char", g.out_char, e.out_char);
				if (g.in_consumed !== e.in_consumed)
					report("in_consumed", g.in_consumed, e.in_consumed);
				if (g.halted !== e.halted) report("halted", g.halted, e.halted);
				if (g.fault !== e.fault) report("fault", g.fault, e.fault);
				if (g.fault_code !== e.fault_code)
					report("fault_code", g.fault_code, e.fault_code);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	sum_if #(.T(sum_pkg::req_t)) req_ch ();
	sum_if #(.T(sum_pkg::rsp_t)) rsp_ch ();
	um_shadow sh;
	int cyc;
	int sent;
	bit calm;
	bit held;
	int stall;

	segmented_universal_machine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial clk = 0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cyc++;
		if (cyc == LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function int gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function logic [31:0] mk(logic [3:0] op, int a, int b, int c);
		logic [18:0] junk;
		junk = 19'($urandom);
		return {op, junk, 3'(a), 3'(b), 3'(c)};
	endfunction

	function logic [31:0] lv(int a, logic [31:0] v);
		return {sum_pkg::OP_LDVAL, 3'(a), v[24:0]};
	endfunction

	function logic [31:0] some_value();
		if ($urandom_range(0, 1)) return $urandom_range(0, 20);
		return $urandom;
	endfunction

	task send(bit run, logic [31:0] w);
		sum_pkg::req_t q;
		int g;
		q.opcode = run;
		q.load_word = w;
		q.in_char = 8'($urandom);
		q.in_eof = $urandom_range(0, 3) == 0;
		req_ch.valid <= 1;
		req_ch.data <= q;
		do @(posedge clk); while (!req_ch.ready);
		sh.note_request(q);
		sent++;
		if (sent % 150 == 0) calm = $urandom_range(0, 2) == 0;
		g = gap();
		if (g > 0) begin
			req_ch.valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Appends the words to the program, then runs until the machine stops or the counter reaches its end.
	task emit(logic [31:0] ws[$]);
		foreach (ws[i]) send(0, ws[i]);
		while (!sh.stopped && sh.pc < sh.len[0]) send(1, $urandom);
	endtask

	// Replaces the program with a newly mapped small segment and resumes at its last word.
	task copy_program();
		int n, id;
		n = $urandom_range(1, 8);
		if (sh.fcount == 0 && sh.fresh >= sum_pkg::NUM_SEGMENTS) begin
			id = $urandom_range(1, sum_pkg::NUM_SEGMENTS - 1);
			emit('{lv(7, id), mk(sum_pkg::OP_UNMAP, 0, 0, 7)});
		end
		emit('{lv(6, n), mk(sum_pkg::OP_MAP, 0, 7, 6), lv(6, n - 1),
			mk(sum_pkg::OP_LDPRG, 0, 7, 6)});
	endtask

	// Jumps within the program over a word that would otherwise fault.
	task skip_jump();
		int l;
		l = sh.len[0];
		emit('{lv(4, 0), lv(5, l + 4), mk(sum_pkg::OP_LDPRG, 0, 4, 5), mk(4'hF, 1, 2, 3),
			mk(sum_pkg::OP_CMOV, 1, 2, 3)});
	endtask

	task random_step();
		int k;
		logic [3:0] op;
		logic [31:0] w;
		k = $urandom_range(0, 99);
		if (sh.len[0] > 1000 || k < 2) copy_program();
		else if (k < 4) skip_jump();
		else begin
			op = 4'($urandom_range(0, 13));
			if (op == sum_pkg::OP_LDVAL) w = lv($urandom_range(0, 7), some_value());
			else w = mk(op, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
			if (sh.would_stop(w) || (op == sum_pkg::OP_MAP && $urandom_range(0, 3) != 0))
				w = lv($urandom_range(0, 7), some_value());
			emit('{w});
		end
	endtask

	task stop_machine();
		case ($urandom_range(1, 8))
			1: emit('{lv(0, 0), mk(sum_pkg::OP_DIV, 1, 1, 0)});
			2: emit('{lv(0, 64), mk(sum_pkg::OP_LOAD, 1, 0, 0)});
			3: emit('{lv(0, 2000), mk(sum_pkg::OP_MAP, 0, 1, 0)});
			4: emit('{lv(0, 300), mk(sum_pkg::OP_OUT, 0, 0, 0)});
			5: emit('{lv(0, 0), mk(sum_pkg::OP_UNMAP, 0, 0, 0)});
			6: begin
				if ($urandom_range(0, 1)) send(1, $urandom);
				else emit('{lv(1, 0), lv(0, 1500), mk(sum_pkg::OP_LDPRG, 0, 1, 0)});
			end
			7: emit('{mk(4'd14 + 4'($urandom_range(0, 1)), 0, 0, 0)});
			default: emit('{mk(sum_pkg::OP_HALT, 0, 0, 0)});
		endcase
	endtask

	initial begin
		sh = new();
		req_ch.valid = 0;
		req_ch.data = '0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		emit('{lv(7, 32'h1FF_FFFF), lv(0, 0), mk(sum_pkg::OP_NAND, 1, 0, 0),
			mk(sum_pkg::OP_ADD, 2, 1, 1), mk(sum_pkg::OP_MUL, 3, 1, 1),
			mk(sum_pkg::OP_DIV, 4, 1, 7), mk(sum_pkg::OP_CMOV, 5, 1, 0),
			mk(sum_pkg::OP_CMOV, 5, 1, 3), mk(sum_pkg::OP_OUT, 0, 0, 4), lv(6, 255),
			mk(sum_pkg::OP_OUT, 0, 0, 6), mk(sum_pkg::OP_IN, 0, 0, 2), lv(6, 3),
			mk(sum_pkg::OP_MAP, 0, 5, 6), mk(sum_pkg::OP_STORE, 5, 0, 1),
			mk(sum_pkg::OP_LOAD, 3, 5, 0), mk(sum_pkg::OP_UNMAP, 0, 0, 5),
			mk(sum_pkg::OP_MAP, 0, 4, 6)});
		skip_jump();
		copy_program();
		req_ch.valid <= 0;
		while (sh.due_results.size() != 0) @(posedge clk);
		while (sent + (sum_pkg::SEGMENT_WORDS - sh.len[0]) < ITEMS) random_step();
		stop_machine();
		repeat (5) send(1, $urandom);
		while (sh.len[0] < sum_pkg::SEGMENT_WORDS) send(0, $urandom);
		repeat (3) send(0, $urandom);
		repeat (5) send(1, $urandom);
		req_ch.valid <= 0;
		while (sh.due_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sh.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		rsp_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) sh.check_result(rsp_ch.data);
			if (!held && sh.checked >= 300) begin
				held = 1;
				rsp_ch.ready <= 0;
				repeat (600) @(posedge clk);
			end else if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 0;
			end else begin
				stall = gap();
				rsp_ch.ready <= stall == 0;
			end
		end
	end
endmodule
